// ----- hw/rtl/wsp_pkg.sv -----
// Shared types and constants for the world-to-screen projection block.
package wsp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned VpW    = 14;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ClipW  = 68;   // sum of three Q.32 products and a translation
  localparam int unsigned MagW   = 69;   // |x + w| may need one more bit
  localparam int unsigned QuoW   = 50;   // 18 integer bits, 32 fraction bits
  localparam int unsigned QBitW  = 6;

  localparam logic [DataW-1:0] BehindQ16 = 32'hFC18_0000;
  localparam logic [VpW-1:0]   WidthRst  = 14'd1920;
  localparam logic [VpW-1:0]   HeightRst = 14'd1080;

  typedef enum logic [0:0] {
    FUNC_LOAD    = 1'b0,
    FUNC_PROJECT = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV,
    ST_SCALE,
    ST_DONE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;    // latch the accepted request
    logic       write_mat;  // store one matrix entry
    logic       mac_clear;
    logic       mac_step;   // one product term
    logic       div_init;   // start a division for the current axis
    logic       div_step;   // one quotient bit
    logic       scale;      // multiply quotient by viewport size
    logic       finish;     // write result register for the current axis
    logic       axis;       // 0 = x, 1 = y
    logic       behind;     // write behind-viewer result
    logic       out_load;   // present result
    logic       out_clear;  // result taken
  } wsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_project;
    logic w_pos;
    logic mac_last;
    logic div_last;
    logic out_valid;
    logic out_ready;
  } wsp_sts_t;

endpackage

// ----- hw/rtl/wsp_req_if.sv -----
// Request and result channel interfaces.
interface wsp_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [wsp_pkg::IdxW-1:0]  entry_index;
  logic signed [31:0]        entry_value;
  logic signed [31:0]        pos_x;
  logic signed [31:0]        pos_y;
  logic signed [31:0]        pos_z;
  modport source (output valid, func, entry_index, entry_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, func, entry_index, entry_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface wsp_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;
  logic               visible;
  modport source (output valid, screen_x, screen_y, depth, visible, input ready);
  modport sink (input valid, screen_x, screen_y, depth, visible, output ready);
endinterface

// ----- hw/rtl/world_to_screen_projection.sv -----
// Top level of the world-to-screen projection block.
//
//  channel | dir | fields
//  req     | in  | func, entry_index, entry_value, pos_x, pos_y, pos_z
//  res     | out | screen_x, screen_y, depth, visible (one per project request)
//  cfg     | in  | cfg_we, cfg_index, cfg_data (0 = width, 1 = height)
//
// A load request latches the entry and then writes it. A project request goes
// from acceptance to the next acceptance: latch, 16 multiply-accumulate steps
// through one 32x32 multiplier, test w, two passes (setup, 50-bit restoring
// division by clip w, scale, write) sharing one divider, present the result;
// a point behind the viewer skips both division passes.
// Reset (synchronous) clears the matrix and restores 1920x1080.
// A stalled result holds the block until it is taken.
module world_to_screen_projection (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  wsp_req_if.sink     req,
  wsp_res_if.source   res
);

  wsp_pkg::wsp_cmd_t cmd;
  wsp_pkg::wsp_sts_t sts;

  wsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (req.func),
    .entry_index (req.entry_index),
    .entry_value (req.entry_value),
    .pos_x       (req.pos_x),
    .pos_y       (req.pos_y),
    .pos_z       (req.pos_z),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (res.ready),
    .out_valid   (res.valid),
    .screen_x    (res.screen_x),
    .screen_y    (res.screen_y),
    .depth       (res.depth),
    .visible     (res.visible)
  );

endmodule

// ----- hw/rtl/wsp_ctrl.sv -----
// Sequencer for loads and projections.
module wsp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsp_pkg::wsp_sts_t sts,
  output wsp_pkg::wsp_cmd_t cmd
);

  wsp_pkg::state_t state, state_next;
  logic axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsp_pkg::ST_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      wsp_pkg::ST_IDLE: begin
        if (in_valid) state_next = wsp_pkg::ST_LOAD;
      end
      wsp_pkg::ST_LOAD: begin
        state_next = sts.is_project ? wsp_pkg::ST_MAC : wsp_pkg::ST_IDLE;
      end
      wsp_pkg::ST_MAC: begin
        if (sts.mac_last) state_next = wsp_pkg::ST_CHECK;
      end
      wsp_pkg::ST_CHECK: begin
        axis_next  = 1'b0;
        state_next = sts.w_pos ? wsp_pkg::ST_DIV_INIT : wsp_pkg::ST_OUT;
      end
      wsp_pkg::ST_DIV_INIT: state_next = wsp_pkg::ST_DIV;
      wsp_pkg::ST_DIV: begin
        if (sts.div_last) state_next = wsp_pkg::ST_SCALE;
      end
      wsp_pkg::ST_SCALE: state_next = wsp_pkg::ST_DONE;
      wsp_pkg::ST_DONE: begin
        if (axis) begin
          state_next = wsp_pkg::ST_OUT;
        end else begin
          axis_next  = 1'b1;
          state_next = wsp_pkg::ST_DIV_INIT;
        end
      end
      wsp_pkg::ST_OUT: begin
        if (!sts.out_valid || sts.out_ready) state_next = wsp_pkg::ST_IDLE;
      end
      default: state_next = wsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    in_ready     = 1'b0;
    cmd.out_clear = sts.out_valid && sts.out_ready;
    case (state)
      wsp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      wsp_pkg::ST_LOAD: begin
        cmd.write_mat = !sts.is_project;
        cmd.mac_clear = sts.is_project;
      end
      wsp_pkg::ST_MAC:      cmd.mac_step = 1'b1;
      wsp_pkg::ST_CHECK:    cmd.behind   = !sts.w_pos;
      wsp_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      wsp_pkg::ST_DIV:      cmd.div_step = 1'b1;
      wsp_pkg::ST_SCALE:    cmd.scale    = 1'b1;
      wsp_pkg::ST_DONE:     cmd.finish   = 1'b1;
      wsp_pkg::ST_OUT: begin
        cmd.out_load = !sts.out_valid || sts.out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/wsp_dp.sv -----
// Matrix store, multiply-accumulate, shared divider and output register.
module wsp_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [wsp_pkg::VpW-1:0]   cfg_data,
  input  logic                      func,
  input  logic [wsp_pkg::IdxW-1:0]  entry_index,
  input  logic signed [31:0]        entry_value,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        pos_z,
  input  wsp_pkg::wsp_cmd_t         cmd,
  output wsp_pkg::wsp_sts_t         sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [31:0]        screen_x,
  output logic signed [31:0]        screen_y,
  output logic signed [31:0]        depth,
  output logic                      visible
);

  localparam int unsigned CW = wsp_pkg::ClipW;
  localparam int unsigned MW = wsp_pkg::MagW;
  localparam int unsigned QW = wsp_pkg::QuoW;

  logic [wsp_pkg::VpW-1:0] vp_w, vp_h;
  logic signed [31:0] mat [16];
  logic               r_func;
  logic [3:0]         r_idx;
  logic signed [31:0] r_val, px, py, pz;

  // MAC: 16 steps, one product a cycle; step = {col, row}
  logic [3:0]          step;
  logic signed [63:0]  prod;
  logic signed [CW-1:0] acc;
  logic signed [CW-1:0] cx, cy, cz, cw;
  logic signed [31:0]  coord;
  logic [3:0]          mat_sel;

  // divider
  logic [MW-1:0]        rem;
  logic [QW-1:0]        quo;
  logic [wsp_pkg::QBitW-1:0] qbit;
  logic                 neg, ovf;
  logic signed [CW:0]   a_val;
  logic [MW-1:0]        a_mag;
  logic [MW:0]          rem_sh, rem_sub;
  logic [QW+wsp_pkg::VpW-1:0] sprod;
  logic [QW+wsp_pkg::VpW-18:0] smag;
  logic signed [31:0]   axis_res;
  logic signed [31:0]   rx, ry;

  // depth and behind flag
  logic signed [CW-17:0] dz;
  logic signed [31:0]    dsat;
  logic                  behind_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_w <= wsp_pkg::WidthRst;
      vp_h <= wsp_pkg::HeightRst;
    end else if (cfg_we) begin
      if (cfg_index == wsp_pkg::CFG_WIDTH) vp_w <= cfg_data;
      else                                 vp_h <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] <= '0;
    end else if (cmd.write_mat) begin
      mat[r_idx] <= r_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_func <= func;
      r_idx  <= entry_index;
      r_val  <= entry_value;
      px     <= pos_x;
      py     <= pos_y;
      pz     <= pos_z;
    end
  end

  assign mat_sel = {step[1:0], step[3:2]};
  always_comb begin
    case (step[1:0])
      2'd0:    coord = px;
      2'd1:    coord = py;
      2'd2:    coord = pz;
      default: coord = 32'sd0;
    endcase
  end

  // translation term: entry * 2^16 here, so the common >>> 8 leaves entry * 2^8
  always_comb begin
    if (step[1:0] == 2'd3) prod = {{16{mat[mat_sel][31]}}, mat[mat_sel], 16'd0};
    else                   prod = mat[mat_sel] * coord;
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clear) begin
      step <= '0;
      acc  <= '0;
    end else if (cmd.mac_step) begin
      step <= step + 4'd1;
      if (step[1:0] == 2'd3) begin
        acc <= '0;
        case (step[3:2])
          2'd0:    cx <= acc + CW'(prod >>> 8);
          2'd1:    cy <= acc + CW'(prod >>> 8);
          2'd2:    cz <= acc + CW'(prod >>> 8);
          default: cw <= acc + CW'(prod >>> 8);
        endcase
      end else begin
        acc <= acc + CW'(prod >>> 8);
      end
    end
  end

  // divider: restoring, 50 quotient bits, one per cycle
  // remainder starts at |a| >> 18; the low 18 bits of |a| and 32 zeros are shifted in
  assign a_val = cmd.axis ? ((CW+1)'(cw) - (CW+1)'(cy)) : ((CW+1)'(cx) + (CW+1)'(cw));
  assign a_mag = a_val[CW] ? MW'(-a_val) : MW'(a_val);
  assign rem_sh  = {rem, quo[QW-1]};
  assign rem_sub = rem_sh - (MW+1)'(unsigned'(cw));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= MW'(a_mag[MW-1:18]);
      quo  <= {a_mag[17:0], 32'd0};
      neg  <= a_val[CW];
      // integer quotient of 2^18 or more saturates
      ovf  <= (MW'(a_mag[MW-1:18]) >= MW'(unsigned'(cw)));
      qbit <= '0;
    end else if (cmd.div_step) begin
      qbit <= qbit + 1'b1;
      if (!rem_sub[MW]) begin
        rem <= rem_sub[MW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[MW-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  assign sts.div_last = (qbit == wsp_pkg::QBitW'(QW-1));

  always_ff @(posedge clk) begin
    if (cmd.scale) sprod <= quo * (QW+wsp_pkg::VpW)'(cmd.axis ? vp_h : vp_w);
  end
  assign smag = sprod[QW+wsp_pkg::VpW-1:17];

  always_comb begin
    if ((cmd.axis ? vp_h : vp_w) == '0) axis_res = '0;
    else if (ovf) axis_res = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else if (!neg) axis_res = (smag > 47'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(smag);
    else axis_res = (smag > 47'h8000_0000) ? 32'sh8000_0000 : 32'(-smag);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.axis) ry <= axis_res;
      else          rx <= axis_res;
    end
  end

  // depth = sat(floor(cz / 2^16))
  assign dz = (CW-16)'(cz >>> 16);
  assign dsat = (dz > (CW-16)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                (dz < (CW-16)'(32'sh8000_0000)) ? 32'sh8000_0000 : 32'(dz);

  always_ff @(posedge clk) begin
    if (cmd.behind) behind_q <= 1'b1;
    else if (cmd.mac_clear) behind_q <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (cmd.out_clear) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      screen_x <= behind_q ? wsp_pkg::BehindQ16 : rx;
      screen_y <= behind_q ? wsp_pkg::BehindQ16 : ry;
      depth    <= behind_q ? 32'sd0 : dsat;
      visible  <= !behind_q;
    end
  end

  assign sts.is_project = (r_func == wsp_pkg::FUNC_PROJECT);
  assign sts.w_pos      = !cw[CW-1] && (cw != '0);
  assign sts.mac_last   = (step == 4'd15);
  assign sts.out_valid  = out_valid;
  assign sts.out_ready  = out_ready;

endmodule

// ----- bench/wsp_tb_pkg.sv -----
`timescale 1ns / 100ps
// Bench-side constants used by the testbench.
package wsp_tb_pkg;
  localparam int unsigned QuoLimit = 18;
  localparam int unsigned TimeoutCycles = 20000;
endpackage

// ----- bench/wsp_tb_if.sv -----
`timescale 1ns / 100ps
// Bench-side bundle for the configuration write port.
interface wsp_tb_cfg_if;
  logic        we;
  logic        idx;
  logic [13:0] wdata;
endinterface

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the world-to-screen projection block.
module tb;

  logic clk;
  logic rst;

  wsp_tb_cfg_if cfg ();
  wsp_req_if req ();
  wsp_res_if res ();

  world_to_screen_projection i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg.we), .cfg_index(cfg.idx),
    .cfg_data(cfg.wdata), .req(req), .res(res)
  );

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] dz;
    logic vis;
  } screen_pt_t;

  // predictor state
  logic signed [31:0] mat [16];
  logic [13:0] vp_w, vp_h;
  screen_pt_t expected_pts [$];
  screen_pt_t exp_pt;

  int errors, results_seen, idle_cycles, points_sent;
  bit idling_on, hold_res;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [67:0] clip_col(int col, logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [67:0] acc;
    logic signed [63:0] p;
    p = 64'(mat[col]) * 64'(px); acc = 68'(p >>> 8);
    p = 64'(mat[4 + col]) * 64'(py); acc += 68'(p >>> 8);
    p = 64'(mat[8 + col]) * 64'(pz); acc += 68'(p >>> 8);
    acc += 68'(mat[12 + col]) <<< 8;
    return acc;
  endfunction

  // S*a/(2w), toward zero, saturated
  function automatic logic signed [31:0] axis_to_pixel(logic signed [68:0] a,
      logic signed [67:0] w, logic [13:0] s);
    logic [68:0] mag, ip, r, wu;
    logic [127:0] q, prod;
    if (s == 0) return 0;
    mag = (a < 0) ? 69'(-a) : 69'(a);
    wu = 69'(w);
    ip = mag / wu;
    r = mag % wu;
    if (ip >= (69'd1 << wsp_tb_pkg::QuoLimit))
      return (a < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    q = (128'(ip) << 32) | 128'(((128'(r) << 32)) / 128'(wu));
    prod = (q * 128'(s)) >> 17;
    if (a >= 0) return (prod > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(prod);
    if (prod > 128'h8000_0000) return 32'sh8000_0000;
    return 32'(-prod);
  endfunction

  function automatic screen_pt_t project_point(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [67:0] cx, cy, cz, cw, d;
    screen_pt_t r;
    cx = clip_col(0, px, py, pz); cy = clip_col(1, px, py, pz);
    cz = clip_col(2, px, py, pz); cw = clip_col(3, px, py, pz);
    if (cw > 0) begin
      r.sx = axis_to_pixel(69'(cx) + 69'(cw), cw, vp_w);
      r.sy = axis_to_pixel(69'(cw) - 69'(cy), cw, vp_h);
      d = cz >>> 16;
      r.dz = (d > 68'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (d < -68'sh8000_0000) ? 32'sh8000_0000 : 32'(d);
      r.vis = 1;
    end else begin
      r.sx = wsp_pkg::BehindQ16; r.sy = wsp_pkg::BehindQ16; r.dz = 0; r.vis = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // random idle burst on the request side
  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop valid after the last request of a burst
  task automatic pause_req();
    req.valid <= 0;
  endtask

  // send one request, update the predictor at acceptance
  task automatic send_req(wsp_pkg::func_t f, logic [3:0] idx, logic [31:0] val,
      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    maybe_idle();
    req.valid <= 1; req.func <= f; req.entry_index <= idx; req.entry_value <= val;
    req.pos_x <= x; req.pos_y <= y; req.pos_z <= z;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (f == wsp_pkg::FUNC_LOAD) mat[idx] = val;
    else begin
      expected_pts.push_back(project_point(x, y, z));
      points_sent++;
    end
  endtask

  task automatic load_entry(int idx, logic [31:0] v);
    send_req(wsp_pkg::FUNC_LOAD, 4'(idx), v, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_req(wsp_pkg::FUNC_PROJECT, 4'($urandom), $urandom, x, y, z);
  endtask

  // wait until idle, then write a viewport register
  task automatic set_viewport(wsp_pkg::cfg_idx_t idx, logic [13:0] v);
    pause_req();
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    cfg.we <= 1; cfg.idx <= idx; cfg.wdata <= v;
    @(posedge clk);
    cfg.we <= 0;
    if (idx == wsp_pkg::CFG_WIDTH) vp_w = v; else vp_h = v;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      results_seen++;
      if (expected_pts.size() == 0) begin
        report_mismatch("unexpected result", res.screen_x, 32'h0);
      end else begin
        exp_pt = expected_pts.pop_front();
        if (res.screen_x !== exp_pt.sx) report_mismatch("screen_x", res.screen_x, exp_pt.sx);
        if (res.screen_y !== exp_pt.sy) report_mismatch("screen_y", res.screen_y, exp_pt.sy);
        if (res.depth !== exp_pt.dz) report_mismatch("depth", res.depth, exp_pt.dz);
        if (res.visible !== exp_pt.vis)
          report_mismatch("visible", 32'(res.visible), 32'(exp_pt.vis));
      end
    end
  end

  // random back-pressure on the result side
  initial begin
    int stall;
    res.ready = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_res) res.ready <= 0;
      else if (stall > 0) begin
        stall--; res.ready <= 0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 5); res.ready <= 0;
      end else res.ready <= 1;
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > wsp_tb_pkg::TimeoutCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
    endcase
  endfunction

  // a plausible camera matrix with random perturbation, w mostly positive
  task automatic load_camera();
    for (int i = 0; i < 16; i++) begin
      logic [31:0] v;
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = 0;
        default: v = 32'($signed($urandom_range(0, 4096)) - 2048) <<< 12;
      endcase
      if (i == 11 || i == 15) v = 32'($urandom_range(1, 64)) <<< 22;
      load_entry(i, v);
    end
  endtask

  task automatic test_directed();
    // all-zero matrix: w = 0, point behind
    project(32'h7FFF_FFFF, 32'h8000_0000, 0);
    // identity-like with w = 1
    for (int i = 0; i < 16; i++) load_entry(i, (i % 5 == 0) ? 32'h0100_0000 : 0);
    project(0, 0, 0);
    project(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
    project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // negative w: behind
    load_entry(15, 32'hFF00_0000);
    project(0, 0, 0);
    // tiny w gives saturation
    load_entry(15, 32'h0000_0001);
    project(32'h0100_0000, 32'hFF00_0000, 0);
    project(32'hFF00_0000, 32'h0100_0000, 0);
    load_entry(0, 32'h7FFF_FFFF);
    load_entry(15, 32'h8000_0000);
    project(32'h8000_0000, 0, 0);
  endtask

  task automatic test_viewports();
    logic [13:0] sizes [6] = '{14'd0, 14'd1, 14'd8192, 14'h3FFF, 14'd640, 14'd1080};
    foreach (sizes[k]) begin
      set_viewport(wsp_pkg::CFG_WIDTH, sizes[k]);
      set_viewport(wsp_pkg::CFG_HEIGHT, sizes[5 - k]);
      load_camera();
      repeat (8) project(rand_coord(), rand_coord(), rand_coord());
    end
    set_viewport(wsp_pkg::CFG_WIDTH, 14'd1920);
    set_viewport(wsp_pkg::CFG_HEIGHT, 14'd1080);
  endtask

  task automatic test_back_pressure();
    // result side held off long enough for the request side to stall
    int held;
    hold_res = 1;
    fork
      begin
        held = 0;
        while (held < 600) begin @(posedge clk); held++; end
        hold_res = 0;
      end
      repeat (6) project(rand_coord(), rand_coord(), rand_coord());
    join
  endtask

  task automatic test_random(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if (sent > n - 150) idling_on = 0;
      if ($urandom_range(0, 19) == 0) begin load_camera(); sent += 16; end
      else if ($urandom_range(0, 5) == 0) begin
        load_entry($urandom_range(0, 15), $urandom); sent++;
      end else begin
        project(rand_coord(), rand_coord(), rand_coord()); sent++;
      end
    end
  endtask

  initial begin
    int tail;
    rst = 1; cfg.we = 0; cfg.idx = 0; cfg.wdata = 0;
    req.valid = 0; req.func = 0; req.entry_index = 0; req.entry_value = 0;
    req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
    errors = 0; results_seen = 0; points_sent = 0;
    idling_on = 1; hold_res = 0;
    foreach (mat[i]) mat[i] = 0;
    vp_w = wsp_pkg::WidthRst; vp_h = wsp_pkg::HeightRst;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed();
    test_viewports();
    test_back_pressure();
    test_random(1150);
    pause_req();

    tail = 0;
    while (expected_pts.size() != 0 && tail < 200000) begin @(posedge clk); tail++; end
    repeat (150) @(posedge clk);
    $display("Projected %0d points, %0d results checked, across viewports 0..16383.",
             points_sent, results_seen);
    if (errors == 0 && expected_pts.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
